[design/dafw_pkg.sv]
// shared types and constants for the d-axis flux weakening block
package dafw_pkg;

  // serial multiplier geometry
  localparam int DIGIT_W    = 4;
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 16;
  localparam int MUL_P_W    = 33;
  localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_ENTER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_EXIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INJECT_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INJECT_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_D_SLEW_LIMIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd7;

  // filter coefficient of exactly one
  localparam logic [16:0] COEFF_ONE = 17'h10000;

  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] d_command;
    logic               weaken_allowed;
  } in_t;

  typedef struct packed {
    logic signed [15:0] d_reference;
    logic signed [15:0] injection;
    logic               weakening_on;
  } out_t;

  typedef struct packed {
    logic               auto_enable;
    logic [14:0]        speed_enter;
    logic [14:0]        speed_exit;
    logic [15:0]        inject_gain;
    logic signed [15:0] inject_floor;
    logic [16:0]        filter_coeff;
    logic [15:0]        d_slew_limit;
    logic [14:0]        current_limit;
  } cfg_t;

endpackage

[design/dafw_mul.sv]
// digit-serial unsigned multiplier, one multiplier digit per cycle
module dafw_mul import dafw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] product
);

  localparam int CNT_W = (MUL_DIGITS > 1) ? $clog2(MUL_DIGITS) : 1;

  logic [MUL_P_W-1:0] a_r, a_nxt;
  logic [MUL_B_W-1:0] b_r, b_nxt;
  logic [MUL_P_W-1:0] p_r, p_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [MUL_P_W-1:0] pp;

  always_comb begin
    pp       = a_r * MUL_P_W'(b_r[DIGIT_W-1:0]);
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = MUL_P_W'(a);
      b_nxt    = b;
      p_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // multiplicand walks left while the multiplier digits walk out the bottom
      p_nxt   = p_r + pp;
      a_nxt   = a_r << DIGIT_W;
      b_nxt   = b_r >> DIGIT_W;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(MUL_DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign done    = done_r;
  assign product = p_r;

endmodule

[design/dafw_core.sv]
// weakening hysteresis, injection filter and slewed d output sequencer
module dafw_core import dafw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  item,
  input  cfg_t cfg,
  input  logic slot_free,
  output logic idle,
  output logic res_valid,
  output out_t res
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_INJ    = 5'b00010,
    ST_FSTART = 5'b00100,
    ST_FILT   = 5'b01000,
    ST_SLEW   = 5'b10000
  } st_t;

  st_t                state_r, state_nxt;
  logic               active_r, active_nxt;
  logic signed [15:0] filt_r, filt_nxt;
  logic signed [15:0] dout_r, dout_nxt;
  logic signed [15:0] cmd_r, cmd_nxt;
  logic signed [15:0] target_r, target_nxt;
  logic               neg_r, neg_nxt;

  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_p;

  logic signed [16:0] spd_ext;
  logic [16:0]        mag;
  logic signed [17:0] over;
  logic               bypass;
  logic               act_new;
  logic signed [15:0] lo;
  logic [16:0]        neg_lo;
  logic signed [15:0] tgt_mul;
  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic [MUL_P_W-1:0] rnd;
  logic [16:0]        step;
  logic signed [17:0] step_s;
  logic signed [17:0] filt_sum;
  logic signed [15:0] filt_new;
  logic signed [18:0] tgt_d;
  logic signed [18:0] dout_e;
  logic signed [18:0] delta;
  logic signed [18:0] slew_s;
  logic signed [18:0] next_d;
  logic signed [18:0] lim_s;
  logic signed [18:0] d_clamp;

  dafw_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_comb begin
    // speed magnitude and overspeed
    spd_ext = {item.speed[15], item.speed};
    mag     = spd_ext[16] ? 17'(-spd_ext) : 17'(spd_ext);
    over    = $signed({1'b0, mag}) - $signed({3'b000, cfg.speed_enter});
    bypass  = !item.weaken_allowed || !cfg.auto_enable;
    act_new = active_r ? !(mag <= {2'b00, cfg.speed_exit})
                       : (mag >= {2'b00, cfg.speed_enter});

    // a floor above zero acts as zero
    lo      = (!cfg.inject_floor[15] && cfg.inject_floor != 16'sd0) ? 16'sd0
                                                                    : cfg.inject_floor;
    neg_lo  = 17'(-$signed({lo[15], lo}));
    tgt_mul = (mul_p >= MUL_P_W'(neg_lo)) ? lo : $signed(16'(-mul_p[15:0]));

    // filter step, rounded half away from zero on the magnitude
    diff     = $signed({target_r[15], target_r}) - $signed({filt_r[15], filt_r});
    diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
    rnd      = mul_p + MUL_P_W'(32768);
    step     = rnd[32:16];
    step_s   = $signed({1'b0, step});
    filt_sum = neg_r ? $signed({{2{filt_r[15]}}, filt_r}) - step_s
                     : $signed({{2{filt_r[15]}}, filt_r}) + step_s;
    if (filt_sum > 18'sd0) begin
      filt_new = 16'sd0;
    end else if (filt_sum < -18'sd32768) begin
      filt_new = -16'sd32768;
    end else begin
      filt_new = filt_sum[15:0];
    end

    // slew then clamp of the d output
    tgt_d  = $signed({{3{cmd_r[15]}}, cmd_r}) + $signed({{3{filt_r[15]}}, filt_r});
    dout_e = $signed({{3{dout_r[15]}}, dout_r});
    delta  = tgt_d - dout_e;
    slew_s = $signed({3'b000, cfg.d_slew_limit});
    if (delta > slew_s) begin
      next_d = dout_e + slew_s;
    end else if (delta < -slew_s) begin
      next_d = dout_e - slew_s;
    end else begin
      next_d = tgt_d;
    end
    lim_s = $signed({4'b0000, cfg.current_limit});
    if (next_d > lim_s) begin
      d_clamp = lim_s;
    end else if (next_d < -lim_s) begin
      d_clamp = -lim_s;
    end else begin
      d_clamp = next_d;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    filt_nxt   = filt_r;
    dout_nxt   = dout_r;
    cmd_nxt    = cmd_r;
    target_nxt = target_r;
    neg_nxt    = neg_r;
    mul_start  = 1'b0;
    mul_a      = {1'b0, cfg.inject_gain};
    mul_b      = over[15:0];
    res_valid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = item.d_command;
          if (bypass) begin
            active_nxt = 1'b0;
            filt_nxt   = 16'sd0;
            state_nxt  = ST_SLEW;
          end else begin
            active_nxt = act_new;
            if (act_new && !over[17]) begin
              mul_start = 1'b1;
              state_nxt = ST_INJ;
            end else begin
              // below the enter point the target clamps to zero
              target_nxt = 16'sd0;
              state_nxt  = ST_FSTART;
            end
          end
        end
      end
      ST_INJ: begin
        if (mul_done) begin
          target_nxt = tgt_mul;
          state_nxt  = ST_FSTART;
        end
      end
      ST_FSTART: begin
        mul_start = 1'b1;
        mul_a     = cfg.filter_coeff;
        mul_b     = diff_mag[15:0];
        neg_nxt   = diff[16];
        state_nxt = ST_FILT;
      end
      ST_FILT: begin
        if (mul_done) begin
          filt_nxt  = filt_new;
          state_nxt = ST_SLEW;
        end
      end
      ST_SLEW: begin
        if (slot_free) begin
          res_valid = 1'b1;
          dout_nxt  = d_clamp[15:0];
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= 1'b0;
      filt_r   <= 16'sd0;
      dout_r   <= 16'sd0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      filt_r   <= filt_nxt;
      dout_r   <= dout_nxt;
    end
    cmd_r    <= cmd_nxt;
    target_r <= target_nxt;
    neg_r    <= neg_nxt;
  end

  assign idle             = (state_r == ST_IDLE);
  assign res.d_reference  = d_clamp[15:0];
  assign res.injection    = filt_r;
  assign res.weakening_on = active_r;

endmodule

[design/d_axis_flux_weakening_ref.sv]
// top level of the d-axis flux weakening block: config registers and output register
//
// One request per control tick: speed, d command and the mode flag go in, and one result
// with the slewed, clamped d reference, the filtered injection and the weakening flag comes
// out. A request that bypasses weakening (current mode or auto weakening off) goes straight
// to the d-output update; when the weakening flag is off or the speed is below the enter
// point, the injection target is zero and only the filter step uses the multiplier;
// otherwise the injection is computed first. The one 4-bit-digit serial multiplier
// serves both gain times overspeed and the filter step. A finished result sits
// in the output register, so the next request is taken while it waits; only the final
// d-output update waits for that register to free up. Configuration writes take effect on
// the next request and must be made while no request is in flight.
module d_axis_flux_weakening_ref import dafw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  logic core_idle;
  logic res_valid;
  out_t res;
  logic slot_free;
  logic start;

  assign start     = in_valid && core_idle;
  assign in_stall  = !core_idle;
  assign slot_free = !out_valid_r || !out_stall;

  dafw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (in_data),
    .cfg       (cfg_r),
    .slot_free (slot_free),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_AUTO_ENABLE:   cfg_nxt.auto_enable   = cfg_data[0];
        REG_SPEED_ENTER:   cfg_nxt.speed_enter   = cfg_data[14:0];
        REG_SPEED_EXIT:    cfg_nxt.speed_exit    = cfg_data[14:0];
        REG_INJECT_GAIN:   cfg_nxt.inject_gain   = cfg_data[15:0];
        REG_INJECT_FLOOR:  cfg_nxt.inject_floor  = cfg_data[15:0];
        REG_FILTER_COEFF: begin
          // coefficients above one saturate to one
          cfg_nxt.filter_coeff = (cfg_data[16:0] > COEFF_ONE) ? COEFF_ONE : cfg_data[16:0];
        end
        REG_D_SLEW_LIMIT:  cfg_nxt.d_slew_limit  = cfg_data[15:0];
        REG_CURRENT_LIMIT: cfg_nxt.current_limit = cfg_data[14:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  assign out_valid_nxt = res_valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_enable   <= 1'b0;
      cfg_r.speed_enter   <= 15'h7fff;
      cfg_r.speed_exit    <= 15'h7fff;
      cfg_r.inject_gain   <= 16'h0000;
      cfg_r.inject_floor  <= 16'sd0;
      cfg_r.filter_coeff  <= 17'h00000;
      cfg_r.d_slew_limit  <= 16'hffff;
      cfg_r.current_limit <= 15'h7fff;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[dv/d_axis_flux_weakening_ref_tb.sv]
// testbench for the d-axis flux weakening block: predicts every result and checks it
`timescale 1ns / 1ps

module d_axis_flux_weakening_ref_tb;
  import dafw_pkg::*;

  localparam int LIMIT       = 500000;
  localparam int PHASE_ITEMS = 160;
  localparam int PHASES      = 12;

  class flux_weakening_check;
    bit     auto_en;
    int     enter;
    int     exit_thr;
    longint gain;
    int     floor_v;
    longint coeff;
    int     slew;
    int     climit;
    bit     active;
    int     filt;
    int     d_out;
    out_t   dref_due[$];
    int     errors;

    function new();
      restore();
      errors = 0;
    endfunction

    function void restore();
      auto_en  = 1'b0;
      enter    = 32767;
      exit_thr = 32767;
      gain     = 0;
      floor_v  = 0;
      coeff    = 0;
      slew     = 65535;
      climit   = 32767;
      active   = 1'b0;
      filt     = 0;
      d_out    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_AUTO_ENABLE:   auto_en = val[0];
        REG_SPEED_ENTER:   enter = val[14:0];
        REG_SPEED_EXIT:    exit_thr = val[14:0];
        REG_INJECT_GAIN:   gain = val[15:0];
        REG_INJECT_FLOOR:  floor_v = int'($signed(val[15:0]));
        REG_FILTER_COEFF: begin
          coeff = val;
          if (coeff > longint'(COEFF_ONE)) coeff = COEFF_ONE;
        end
        REG_D_SLEW_LIMIT:  slew = val[15:0];
        REG_CURRENT_LIMIT: climit = val[14:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    // hysteresis flag and filtered injection, returns the injection for this tick
    function int weaken(int spd, bit allowed);
      int     mag;
      longint tgt;
      longint lo;
      longint diff;
      longint prod;
      longint mprod;
      longint stp;
      mag = (spd >= 0) ? spd : -spd;
      tgt = 0;
      if (!allowed || !auto_en) begin
        active = 1'b0;
        filt   = 0;
        return 0;
      end
      if (!active) begin
        if (mag >= enter) active = 1'b1;
      end else begin
        if (mag <= exit_thr) active = 1'b0;
      end
      if (active) begin
        lo  = (floor_v > 0) ? 0 : floor_v;
        tgt = clamp(-(gain * (longint'(mag) - longint'(enter))), lo, 0);
      end
      diff  = tgt - longint'(filt);
      prod  = coeff * diff;
      mprod = (prod < 0) ? -prod : prod;
      // round to nearest, ties away from zero
      stp   = (mprod + 32768) / 65536;
      if (prod < 0) stp = -stp;
      filt = int'(clamp(longint'(filt) + stp, -32768, 0));
      return filt;
    endfunction

    function out_t next_dref(in_t req);
      int   spd;
      int   cmd;
      int   inj;
      int   tgt;
      int   delta;
      int   nxt;
      out_t o;
      spd   = req.speed;
      cmd   = req.d_command;
      inj   = weaken(spd, req.weaken_allowed);
      tgt   = cmd + inj;
      delta = tgt - d_out;
      if (delta > slew) nxt = d_out + slew;
      else if (delta < -slew) nxt = d_out - slew;
      else nxt = tgt;
      d_out = int'(clamp(nxt, -climit, climit));
      o.d_reference  = d_out[15:0];
      o.injection    = filt[15:0];
      o.weakening_on = active;
      return o;
    endfunction

    function void take_tick(in_t req);
      dref_due.push_back(next_dref(req));
    endfunction

    function void check_dref(out_t got);
      out_t exp_o;
      if (dref_due.size() == 0) begin
        $error("result with no request pending: d_reference %0d injection %0d flag %0d",
               got.d_reference, got.injection, got.weakening_on);
        errors++;
        return;
      end
      exp_o = dref_due.pop_front();
      if (got.d_reference !== exp_o.d_reference) begin
        $error("d_reference expected %0d got %0d", exp_o.d_reference, got.d_reference);
        errors++;
      end
      if (got.injection !== exp_o.injection) begin
        $error("injection expected %0d got %0d", exp_o.injection, got.injection);
        errors++;
      end
      if (got.weakening_on !== exp_o.weakening_on) begin
        $error("weakening_on expected %0d got %0d", exp_o.weakening_on, got.weakening_on);
        errors++;
      end
    endfunction

    function int pending();
      return dref_due.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int send_idle  = 0;
  int recv_stall = 0;
  int cycles     = 0;

  flux_weakening_check sb = new();

  d_axis_flux_weakening_ref i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.take_tick(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_dref(out_data);
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // unused upper data bits carry noise, the block must ignore them
  task automatic program_regs(input cfg_t c);
    write_reg(REG_AUTO_ENABLE, {16'($urandom_range(65535)), c.auto_enable});
    write_reg(REG_SPEED_ENTER, {2'($urandom_range(3)), c.speed_enter});
    write_reg(REG_SPEED_EXIT, {2'($urandom_range(3)), c.speed_exit});
    write_reg(REG_INJECT_GAIN, {1'($urandom_range(1)), c.inject_gain});
    write_reg(REG_INJECT_FLOOR, {1'($urandom_range(1)), c.inject_floor});
    write_reg(REG_FILTER_COEFF, c.filter_coeff);
    write_reg(REG_D_SLEW_LIMIT, {1'($urandom_range(1)), c.d_slew_limit});
    write_reg(REG_CURRENT_LIMIT, {2'($urandom_range(3)), c.current_limit});
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(input in_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic tick(input int spd, input int cmd, input bit allowed);
    in_t r;
    r.speed          = 16'(spd);
    r.d_command      = 16'(cmd);
    r.weaken_allowed = allowed;
    send_request(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // speeds mostly around the thresholds so the hysteresis keeps switching
  function automatic in_t make_request();
    in_t r;
    int  spd;
    int  cmd;
    int  pick;
    pick = $urandom_range(99);
    if (pick < 40) spd = sb.enter + int'($urandom_range(400)) - 200;
    else if (pick < 55) spd = sb.exit_thr + int'($urandom_range(400)) - 200;
    else if (pick < 75) spd = int'($signed(16'($urandom)));
    else if (pick < 85) spd = sb.enter + int'($urandom_range(8000));
    else begin
      case ($urandom_range(3))
        0: spd = -32768;
        1: spd = 32767;
        2: spd = 0;
        default: spd = -1;
      endcase
    end
    if (pick < 85 && $urandom_range(1) == 1) spd = -spd;
    pick = $urandom_range(99);
    if (pick < 50) cmd = int'($signed(16'($urandom)));
    else if (pick < 80) cmd = int'($urandom_range(4000)) - 2000;
    else cmd = $urandom_range(1) ? 32767 : -32768;
    r.speed          = 16'(sat16(spd));
    r.d_command      = 16'(sat16(cmd));
    r.weaken_allowed = ($urandom_range(99) < 90);
    return r;
  endfunction

  function automatic cfg_t make_settings();
    cfg_t c;
    int   pick;
    int   e;
    c.auto_enable = ($urandom_range(99) < 85);
    pick = $urandom_range(99);
    if (pick < 40) e = $urandom_range(32767);
    else if (pick < 80) e = $urandom_range(4000);
    else e = $urandom_range(1) ? 32767 : 0;
    c.speed_enter = 15'(e);
    pick = $urandom_range(99);
    if (pick < 60) c.speed_exit = 15'(e - int'($urandom_range((e < 1000) ? e : 1000)));
    else if (pick < 85) c.speed_exit = 15'($urandom_range(32767));
    else c.speed_exit = 15'((e + int'($urandom_range(2000)) > 32767) ? 32767
                            : e + int'($urandom_range(2000)));
    pick = $urandom_range(99);
    if (pick < 40) c.inject_gain = 16'($urandom);
    else if (pick < 80) c.inject_gain = 16'($urandom_range(1024));
    else c.inject_gain = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    pick = $urandom_range(99);
    if (pick < 70) c.inject_floor = 16'(-int'($urandom_range(32768)));
    else if (pick < 85) c.inject_floor = $urandom_range(1) ? 16'sh8000 : 16'sh0000;
    else c.inject_floor = 16'($urandom_range(32767, 1));
    pick = $urandom_range(99);
    if (pick < 40) c.filter_coeff = 17'($urandom_range(65536));
    else if (pick < 60) c.filter_coeff = 17'($urandom_range(4096));
    else if (pick < 80) c.filter_coeff = $urandom_range(1) ? COEFF_ONE : 17'd0;
    else c.filter_coeff = 17'($urandom_range(131071, 65537));
    pick = $urandom_range(99);
    if (pick < 45) c.d_slew_limit = 16'($urandom);
    else if (pick < 75) c.d_slew_limit = 16'($urandom_range(2000));
    else if (pick < 95) c.d_slew_limit = 16'hFFFF;
    else c.d_slew_limit = 16'h0000;
    pick = $urandom_range(99);
    if (pick < 60) c.current_limit = 15'($urandom_range(32767));
    else if (pick < 80) c.current_limit = 15'h7FFF;
    else if (pick < 90) c.current_limit = 15'h0000;
    else c.current_limit = 15'($urandom_range(500));
    return c;
  endfunction

  initial begin
    cfg_t c;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: weakening is off
    tick(5000, 1234, 1'b1);
    tick(-32768, -32768, 1'b1);
    wait_idle();

    // ordinary hysteresis with exit below enter
    c.auto_enable   = 1'b1;
    c.speed_enter   = 15'd1000;
    c.speed_exit    = 15'd800;
    c.inject_gain   = 16'd256;
    c.inject_floor  = -16'sd20000;
    c.filter_coeff  = COEFF_ONE;
    c.d_slew_limit  = 16'hFFFF;
    c.current_limit = 15'h7FFF;
    program_regs(c);
    tick(0, 0, 1'b1);
    tick(1000, 100, 1'b1);
    tick(1500, 0, 1'b1);
    tick(-32768, -32768, 1'b1);
    tick(32767, 32767, 1'b1);
    tick(900, 0, 1'b1);
    tick(800, 0, 1'b1);
    tick(2000, 0, 1'b0);
    tick(2000, 0, 1'b1);
    tick(-2000, -1000, 1'b1);
    wait_idle();

    // exit above enter, floor above zero, coefficient above one, tight slew and clamp
    c.speed_enter   = 15'd500;
    c.speed_exit    = 15'd3000;
    c.inject_gain   = 16'hFFFF;
    c.inject_floor  = 16'sd1000;
    c.filter_coeff  = 17'h1FFFF;
    c.d_slew_limit  = 16'd300;
    c.current_limit = 15'd1000;
    program_regs(c);
    tick(600, 32767, 1'b1);
    tick(-600, -32768, 1'b1);
    tick(3500, 0, 1'b1);
    tick(3500, 0, 1'b1);
    tick(100, 0, 1'b0);
    tick(32767, 0, 1'b1);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 71; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 71; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      if (ph == 0) begin
        c.auto_enable   = 1'b1;
        c.speed_enter   = 15'h7FFF;
        c.speed_exit    = 15'h7FFF;
        c.inject_gain   = 16'hFFFF;
        c.inject_floor  = 16'sh8000;
        c.filter_coeff  = 17'h1FFFF;
        c.d_slew_limit  = 16'hFFFF;
        c.current_limit = 15'h7FFF;
      end else if (ph == 1) begin
        c.auto_enable   = 1'b1;
        c.speed_enter   = 15'h0000;
        c.speed_exit    = 15'h0000;
        c.inject_gain   = 16'hFFFF;
        c.inject_floor  = 16'sh8000;
        c.filter_coeff  = 17'd1;
        c.d_slew_limit  = 16'h0000;
        c.current_limit = 15'h0000;
      end else begin
        c = make_settings();
      end
      program_regs(c);
      for (int k = 0; k < PHASE_ITEMS; k++) send_request(make_request());
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
